FILE: rtl/core/voice_block_stream_parser_macros.svh
// Assertion macros shared by the voice block stream parser RTL.
// No dependencies; include by bare file name inside a module body.
`ifndef VOICE_BLOCK_STREAM_PARSER_MACROS_SVH
`define VOICE_BLOCK_STREAM_PARSER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define VBSP_ASSERT_IMP(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (conseq)) \
        else $error("voice block stream parser: implication check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define VBSP_ASSERT_NXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (conseq)) \
        else $error("voice block stream parser: next-cycle check failed");

`endif

FILE: rtl/core/vbsp_pkg.sv
// Package for the voice block stream parser: widths, codes and the result type.
// No dependencies; imported by vbsp_parser and voice_block_stream_parser.
`default_nettype none

package vbsp_pkg;

    localparam int OFFSET_BITS = 24;

    localparam logic [23:0] LIMIT_RESET    = 24'd220000;
    localparam logic [4:0]  FILE_HEAD_LEN  = 5'd26;
    localparam logic [4:0]  BLOCK_HEAD_LEN = 5'd6;

    // Signature bytes of the file header.
    localparam logic [7:0] SIG_C = 8'h43;
    localparam logic [7:0] SIG_R = 8'h72;
    localparam logic [7:0] SIG_E = 8'h65;
    localparam logic [7:0] SIG_A = 8'h61;

    // Block type bytes.
    localparam logic [7:0] BT_END       = 8'd0;
    localparam logic [7:0] BT_SOUND     = 8'd1;
    localparam logic [7:0] BT_MARKER    = 8'd4;
    localparam logic [7:0] BT_REP_START = 8'd6;
    localparam logic [7:0] BT_REP_END   = 8'd7;

    typedef enum logic [2:0] {
        KIND_HDR  = 3'd0,
        KIND_SAMP = 3'd1,
        KIND_MARK = 3'd2,
        KIND_SEEK = 3'd3,
        KIND_END  = 3'd4,
        KIND_ERR  = 3'd5
    } byte_kind_t;

    typedef struct packed {
        byte_kind_t   byte_kind;
        logic [7:0]   sample_byte;
        logic [15:0]  marker_value;
        logic [23:0]  seek_offset;
        logic         large_block_flag;
    } vbsp_result_t;

endpackage

`default_nettype wire

FILE: rtl/core/voice_block_stream_parser.sv
// Voice block stream parser: one result per byte, registered and shown in the cycle after acceptance.
// Throughput is one byte per cycle; the single output register is the only stage,
// and a new byte is taken whenever that register is empty or being emptied.
// Reset (aresetn low, synchronous) empties the output, idles the parser and
// loads the size limit with 220000.
// Depends on vbsp_pkg, vbsp_parser and voice_block_stream_parser_macros.svh.
`default_nettype none

module voice_block_stream_parser
    import vbsp_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic          s_opcode,
    input  wire logic [7:0]    s_data_byte,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [2:0]         m_byte_kind,
    output logic [7:0]         m_sample_byte,
    output logic [15:0]        m_marker_value,
    output logic [23:0]        m_seek_offset,
    output logic               m_large_block_flag,
    input  wire logic          cfg_wr_en,
    input  wire logic [23:0]   cfg_wr_data
);

`include "voice_block_stream_parser_macros.svh"

    logic          accept;
    logic          m_valid_reg, m_valid_next;
    logic [23:0]   limit_reg;
    vbsp_result_t  step_result;
    vbsp_result_t  result_reg;

    assign s_ready      = !m_valid_reg || m_ready;
    assign accept       = s_valid && s_ready;
    assign m_valid_next = accept || (m_valid_reg && !m_ready);

    vbsp_parser u_parser (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .step_en           (accept),
        .opcode            (s_opcode),
        .data_byte         (s_data_byte),
        .large_block_limit (limit_reg),
        .result            (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            limit_reg   <= LIMIT_RESET;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    // The result register needs no reset; it is only seen while valid.
    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= step_result;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_byte_kind        = result_reg.byte_kind;
    assign m_sample_byte      = result_reg.sample_byte;
    assign m_marker_value     = result_reg.marker_value;
    assign m_seek_offset      = result_reg.seek_offset;
    assign m_large_block_flag = result_reg.large_block_flag;

    `VBSP_ASSERT_NXT(a_accept_gives_result, aclk, aresetn, s_valid && s_ready, m_valid)
    `VBSP_ASSERT_IMP(a_no_overwrite, aclk, aresetn, m_valid && !m_ready, !s_ready)
    `VBSP_ASSERT_IMP(a_sample_only_on_sample, aclk, aresetn,
        m_valid && m_byte_kind != KIND_SAMP, m_sample_byte == 8'd0)
    `VBSP_ASSERT_IMP(a_flag_only_on_header, aclk, aresetn,
        m_valid && m_large_block_flag, m_byte_kind == KIND_HDR)

endmodule

`default_nettype wire

FILE: rtl/core/vbsp_parser.sv
// Parse state and per-byte decode of the voice block stream parser.
// Depends on vbsp_pkg; the result is combinational and registered by the top level.
`default_nettype none

module vbsp_parser
    import vbsp_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          step_en,
    input  wire logic          opcode,
    input  wire logic [7:0]    data_byte,
    input  wire logic [23:0]   large_block_limit,
    output vbsp_result_t       result
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TYPE,
        PH_HEAD,
        PH_SND,
        PH_SAMP,
        PH_MARK,
        PH_LOOP
    } phase_t;

    phase_t                   phase_reg, phase_next;
    logic [4:0]               hbc_reg, hbc_next;
    logic [23:0]              size_reg, size_next;
    logic [23:0]              samples_reg, samples_next;
    logic [OFFSET_BITS-1:0]   offset_reg, offset_next;
    logic [OFFSET_BITS-1:0]   loop_reg, loop_next;
    logic [7:0]               marker_low_reg, marker_low_next;

    logic [OFFSET_BITS-1:0]   offset_inc;
    logic [4:0]               hbc_inc;
    logic                     head_bad;

    assign offset_inc = offset_reg + OFFSET_BITS'(1);
    assign hbc_inc    = hbc_reg + 5'd1;

    always_comb begin
        phase_next      = phase_reg;
        hbc_next        = hbc_reg;
        size_next       = size_reg;
        samples_next    = samples_reg;
        offset_next     = offset_reg;
        loop_next       = loop_reg;
        marker_low_next = marker_low_reg;
        result          = '0;
        result.byte_kind = KIND_HDR;
        head_bad        = 1'b0;

        if (!opcode) begin
            // A start clears the whole parse context but not the limit register.
            phase_next      = PH_TYPE;
            hbc_next        = '0;
            size_next       = '0;
            samples_next    = '0;
            offset_next     = '0;
            loop_next       = '0;
            marker_low_next = '0;
        end else begin
            case (phase_reg)
                PH_TYPE: begin
                    hbc_next = '0;
                    case (data_byte)
                        BT_END: begin
                            result.byte_kind = KIND_END;
                            phase_next = PH_IDLE;
                        end
                        BT_SOUND: begin
                            size_next   = '0;
                            hbc_next    = 5'd1;
                            offset_next = offset_inc;
                            phase_next  = PH_SND;
                        end
                        BT_MARKER: begin
                            hbc_next    = 5'd1;
                            offset_next = offset_inc;
                            phase_next  = PH_MARK;
                        end
                        BT_REP_START: begin
                            loop_next   = offset_reg;
                            hbc_next    = 5'd1;
                            offset_next = offset_inc;
                            phase_next  = PH_LOOP;
                        end
                        BT_REP_END: begin
                            // The phase stays on a type byte: the host resumes at the loop start.
                            result.byte_kind   = KIND_SEEK;
                            result.seek_offset = 24'(loop_reg);
                            offset_next        = loop_reg;
                        end
                        SIG_C: begin
                            hbc_next    = 5'd1;
                            offset_next = offset_inc;
                            phase_next  = PH_HEAD;
                        end
                        default: begin
                            result.byte_kind = KIND_ERR;
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
                PH_HEAD: begin
                    head_bad = (hbc_reg == 5'd1 && data_byte != SIG_R) ||
                               (hbc_reg == 5'd2 && data_byte != SIG_E) ||
                               (hbc_reg == 5'd3 && data_byte != SIG_A);
                    if (head_bad) begin
                        result.byte_kind = KIND_ERR;
                        phase_next = PH_IDLE;
                        hbc_next   = '0;
                    end else begin
                        hbc_next    = hbc_inc;
                        offset_next = offset_inc;
                        if (hbc_inc >= FILE_HEAD_LEN) begin
                            hbc_next   = '0;
                            phase_next = PH_TYPE;
                        end
                    end
                end
                PH_SND: begin
                    case (hbc_reg)
                        5'd1: size_next = size_reg | {16'h0000, data_byte};
                        5'd2: size_next = size_reg | {8'h00, data_byte, 8'h00};
                        5'd3: size_next = size_reg | {data_byte, 16'h0000};
                        default: size_next = size_reg;
                    endcase
                    if (hbc_reg == 5'd3) begin
                        // The size counts the rate and codec bytes as well.
                        samples_next = (size_next >= 24'd2) ? size_next - 24'd2 : '0;
                        result.large_block_flag = (samples_next > large_block_limit);
                    end
                    hbc_next    = hbc_inc;
                    offset_next = offset_inc;
                    if (hbc_inc >= BLOCK_HEAD_LEN) begin
                        hbc_next   = '0;
                        phase_next = (samples_next != '0) ? PH_SAMP : PH_TYPE;
                    end
                end
                PH_SAMP: begin
                    result.byte_kind   = KIND_SAMP;
                    result.sample_byte = data_byte;
                    offset_next        = offset_inc;
                    if (samples_reg != '0) begin
                        samples_next = samples_reg - 24'd1;
                    end
                    if (samples_next == '0) begin
                        phase_next = PH_TYPE;
                    end
                end
                PH_MARK: begin
                    if (hbc_reg == 5'd4) begin
                        marker_low_next = data_byte;
                    end else if (hbc_reg == 5'd5) begin
                        result.byte_kind    = KIND_MARK;
                        result.marker_value = {data_byte, marker_low_reg};
                    end
                    hbc_next    = hbc_inc;
                    offset_next = offset_inc;
                    if (hbc_inc >= BLOCK_HEAD_LEN) begin
                        hbc_next   = '0;
                        phase_next = PH_TYPE;
                    end
                end
                PH_LOOP: begin
                    hbc_next    = hbc_inc;
                    offset_next = offset_inc;
                    if (hbc_inc >= BLOCK_HEAD_LEN) begin
                        hbc_next   = '0;
                        phase_next = PH_TYPE;
                    end
                end
                default: begin
                    // Bytes in the idle phase, before a start or after an end or an error, are ignored.
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            hbc_reg        <= '0;
            size_reg       <= '0;
            samples_reg    <= '0;
            offset_reg     <= '0;
            loop_reg       <= '0;
            marker_low_reg <= '0;
        end else if (step_en) begin
            phase_reg      <= phase_next;
            hbc_reg        <= hbc_next;
            size_reg       <= size_next;
            samples_reg    <= samples_next;
            offset_reg     <= offset_next;
            loop_reg       <= loop_next;
            marker_low_reg <= marker_low_next;
        end
    end

endmodule

`default_nettype wire
